@@ rtl/ssir_pkg.sv @@
// shared types and constants for the sorted set insert/remove block
// no dependencies; used by every module of the block
`default_nettype none

package ssir_pkg;

    // store geometry
    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int POS_W    = $clog2(CAPACITY + 1);
    localparam int STAT_W   = 2;
    localparam int OUT_W    = ((STAT_W + 2 * POS_W + 7) / 8) * 8;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic compare;
        logic ins;
        logic rem;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/ssir_cell.sv @@
// one storage cell of the sorted chain: holds one value and its occupied flag
// depends on ssir_pkg; neighbors feed shift data in both directions
`default_nettype none

module ssir_cell (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire ssir_pkg::cell_ctrl_t              ctrl,
    input  wire logic signed [ssir_pkg::DATA_W-1:0] key,
    input  wire logic                              lt_prev,
    input  wire logic signed [ssir_pkg::DATA_W-1:0] value_prev,
    input  wire logic                              valid_prev,
    input  wire logic signed [ssir_pkg::DATA_W-1:0] value_nxt,
    input  wire logic                              valid_nxt,
    output logic signed [ssir_pkg::DATA_W-1:0]     value,
    output logic                                   valid,
    output logic                                   lt,
    output logic                                   eq
);

    logic signed [ssir_pkg::DATA_W-1:0] value_reg;
    logic signed [ssir_pkg::DATA_W-1:0] value_next;
    logic                               valid_reg;
    logic                               valid_next;
    logic                               lt_reg;
    logic                               lt_next;
    logic                               eq_reg;
    logic                               eq_next;

    // compare against the key, then shift or load on update
    always_comb
    begin
        lt_next    = lt_reg;
        eq_next    = eq_reg;
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.compare)
        begin
            lt_next = valid_reg && (value_reg < key);
            eq_next = valid_reg && (value_reg == key);
        end
        // insert: cells below the slot keep, the slot loads the key, the rest move up
        if (ctrl.ins && !lt_reg)
        begin
            if (lt_prev)
            begin
                value_next = key;
                valid_next = 1'b1;
            end
            else
            begin
                value_next = value_prev;
                valid_next = valid_prev;
            end
        end
        // remove: cells from the hit upward take their upper neighbor
        if (ctrl.rem && !lt_reg)
        begin
            value_next = value_nxt;
            valid_next = valid_nxt;
        end
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            lt_reg    <= lt_next;
            eq_reg    <= eq_next;
        end
    end

    // stored value
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

`default_nettype wire

@@ rtl/ssir_locate.sv @@
// finds the insertion slot and the hit flag from the cells' compare flags
// depends on ssir_pkg; fed by the registered flags of all cells
`default_nettype none

module ssir_locate (
    input  wire logic [ssir_pkg::CAPACITY-1:0] lt_vec,
    input  wire logic [ssir_pkg::CAPACITY-1:0] eq_vec,
    output logic [ssir_pkg::POS_W-1:0]         position,
    output logic                               hit
);

    logic [ssir_pkg::CAPACITY-1:0] bnd;
    logic [ssir_pkg::POS_W-1:0]    enc;

    // boundary is the first cell not below the key; at most one is set
    always_comb
    begin
        bnd = ~lt_vec & {lt_vec[ssir_pkg::CAPACITY-2:0], 1'b1};
        enc = '0;
        for (int i = 0; i < ssir_pkg::CAPACITY; i++)
        begin
            enc = enc | (bnd[i] ? ssir_pkg::POS_W'(i) : '0);
        end
    end

    // no boundary means every slot is below the key and the store is full
    assign position = (|bnd) ? enc : ssir_pkg::POS_W'(ssir_pkg::CAPACITY);
    // only the boundary cell can match since values are distinct and sorted
    assign hit = |eq_vec;

endmodule

`default_nettype wire

@@ rtl/sorted_set_insert_remove_top.sv @@
// top level of the sorted set: a chain of value cells, a slot locator and the sequencer
// depends on ssir_pkg, ssir_cell, ssir_locate
`default_nettype none

// channel | dir | handshake          | payload
// s       | in  | s_tvalid/s_tready  | s_tdata = value, s_tuser = opcode
// m       | out | m_tvalid/m_tready  | m_tdata = status, position, count
//
// each word passes three steps: accept, parallel compare in every cell, update
// the update cycle waits while the output register still holds an untaken word
// a new word is accepted while the previous result waits on m
// reset empties the store at once (cell occupied flags clear asynchronously)

module sorted_set_insert_remove_top (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [31:0]                s_tdata,  // [31:0] value
    input  wire logic [0:0]                 s_tuser,  // [0] opcode
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [ssir_pkg::OUT_W-1:0]      m_tdata   // [1:0] status, [8:2] position, [15:9] count
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0]                         state_reg;
    logic [1:0]                         state_next;
    logic signed [ssir_pkg::DATA_W-1:0] key_reg;
    logic                               op_reg;
    logic [ssir_pkg::POS_W-1:0]         count_reg;
    logic [ssir_pkg::POS_W-1:0]         count_next;
    logic                               m_valid_reg;
    logic                               m_valid_next;
    logic [ssir_pkg::STAT_W-1:0]        stat_reg;
    logic [ssir_pkg::STAT_W-1:0]        stat_next;
    logic [ssir_pkg::POS_W-1:0]         pos_reg;
    logic [ssir_pkg::POS_W-1:0]         cnt_out_reg;

    ssir_pkg::cell_ctrl_t               ctrl;
    logic signed [ssir_pkg::DATA_W-1:0] cell_value [ssir_pkg::CAPACITY];
    logic [ssir_pkg::CAPACITY-1:0]      cell_valid;
    logic [ssir_pkg::CAPACITY-1:0]      cell_lt;
    logic [ssir_pkg::CAPACITY-1:0]      cell_eq;
    logic [ssir_pkg::POS_W-1:0]         position;
    logic                               hit;
    logic                               full;
    logic                               out_free;
    logic                               accept;
    logic                               finish;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign finish   = (state_reg == ST_UPD) && out_free;
    assign full     = (count_reg == ssir_pkg::POS_W'(ssir_pkg::CAPACITY));
    assign s_tready = (state_reg == ST_IDLE);

    // commands to the cells
    always_comb
    begin
        ctrl.compare = (state_reg == ST_CMP);
        ctrl.ins     = finish && (op_reg == ssir_pkg::OP_INSERT) && !hit && !full;
        ctrl.rem     = finish && (op_reg == ssir_pkg::OP_REMOVE) && hit;
    end

    // cell chain
    for (genvar i = 0; i < ssir_pkg::CAPACITY; i++)
    begin : g_cell
        logic                               lt_prev;
        logic signed [ssir_pkg::DATA_W-1:0] value_prev;
        logic                               valid_prev;
        logic signed [ssir_pkg::DATA_W-1:0] value_nxt;
        logic                               valid_nxt;

        if (i == 0)
        begin : g_first
            assign lt_prev    = 1'b1;
            assign value_prev = key_reg;
            assign valid_prev = 1'b0;
        end
        else
        begin : g_mid
            assign lt_prev    = cell_lt[i-1];
            assign value_prev = cell_value[i-1];
            assign valid_prev = cell_valid[i-1];
        end

        if (i == ssir_pkg::CAPACITY - 1)
        begin : g_last
            assign value_nxt = key_reg;
            assign valid_nxt = 1'b0;
        end
        else
        begin : g_inner
            assign value_nxt = cell_value[i+1];
            assign valid_nxt = cell_valid[i+1];
        end

        ssir_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .key        (key_reg),
            .lt_prev    (lt_prev),
            .value_prev (value_prev),
            .valid_prev (valid_prev),
            .value_nxt  (value_nxt),
            .valid_nxt  (valid_nxt),
            .value      (cell_value[i]),
            .valid      (cell_valid[i]),
            .lt         (cell_lt[i]),
            .eq         (cell_eq[i])
        );
    end

    // slot and hit from the compare flags
    ssir_locate u_locate (
        .lt_vec   (cell_lt),
        .eq_vec   (cell_eq),
        .position (position),
        .hit      (hit)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_CMP;
            ST_CMP:  state_next = ST_UPD;
            ST_UPD:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // status and count of the finishing word
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins)
            count_next = count_reg + ssir_pkg::POS_W'(1);
        else if (ctrl.rem)
            count_next = count_reg - ssir_pkg::POS_W'(1);

        priority if (op_reg == ssir_pkg::OP_INSERT && hit)
            stat_next = ssir_pkg::STAT_MISS;
        else if (op_reg == ssir_pkg::OP_INSERT && full)
            stat_next = ssir_pkg::STAT_FULL;
        else if (op_reg == ssir_pkg::OP_REMOVE && !hit)
            stat_next = ssir_pkg::STAT_MISS;
        else
            stat_next = ssir_pkg::STAT_DONE;

        m_valid_next = m_valid_reg;
        if (finish)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // input capture and result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= s_tdata;
            op_reg  <= s_tuser[0];
        end
        if (finish)
        begin
            stat_reg    <= stat_next;
            pos_reg     <= position;
            cnt_out_reg <= count_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = ssir_pkg::OUT_W'({cnt_out_reg, pos_reg, stat_reg});

endmodule

`default_nettype wire

@@ rtl/ssir_checker.sv @@
// port-level checks for the sorted set top level, bound to it below
// depends on ssir_pkg and the sorted_set_insert_remove_top ports
`default_nettype none

module ssir_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       s_tvalid,
    input wire logic                       s_tready,
    input wire logic                       m_tvalid,
    input wire logic                       m_tready,
    input wire logic [ssir_pkg::OUT_W-1:0] m_tdata
);

    logic [ssir_pkg::STAT_W-1:0] stat;
    logic [ssir_pkg::POS_W-1:0]  pos;
    logic [ssir_pkg::POS_W-1:0]  cnt;

    assign stat = m_tdata[ssir_pkg::STAT_W-1:0];
    assign pos  = m_tdata[ssir_pkg::STAT_W+ssir_pkg::POS_W-1:ssir_pkg::STAT_W];
    assign cnt  = m_tdata[ssir_pkg::STAT_W+2*ssir_pkg::POS_W-1:ssir_pkg::STAT_W+ssir_pkg::POS_W];

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // one word in flight: input closes right after an accept
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a word is in flight");

    // the slot never lies beyond the count
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pos <= cnt)
        else $error("position beyond stored count");

    // full status only with a full store
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && stat == ssir_pkg::STAT_FULL
            |-> cnt == ssir_pkg::POS_W'(ssir_pkg::CAPACITY))
        else $error("full status with room left");

    // only defined status codes appear
    a_stat_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> stat == ssir_pkg::STAT_DONE || stat == ssir_pkg::STAT_MISS
            || stat == ssir_pkg::STAT_FULL)
        else $error("undefined status code");

endmodule

bind sorted_set_insert_remove_top ssir_checker u_ssir_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
